>>> rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the first-fit segment allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffsa_pkg;

    // table depth default and fixed field widths
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int ADDR_BITS         = 16;
    localparam int SIZE_BITS         = 17;
    localparam int COUNT_BITS        = 5;
    localparam int STATUS_BITS       = 2;

    // size of the address space, one bit wider than a length
    localparam logic [SIZE_BITS:0] SPACE_SIZE = (SIZE_BITS + 1)'(1) << ADDR_BITS;

    // command codes
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // status codes
    localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_OVERLAP = 2'd3;

    // input word
    typedef struct packed {
        logic                 cmd;
        logic [ADDR_BITS-1:0] req_start;
        logic [SIZE_BITS-1:0] req_size;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [ADDR_BITS-1:0]   alloc_start;
        logic [COUNT_BITS-1:0]  free_entries;
    } out_word_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_MOVE,
        S_WRITE,
        S_RESULT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic scan_en;
        logic decide;
        logic move_en;
        logic final_wr;
        logic load_out;
    } ctrl_t;

    // datapath to controller status
    typedef struct packed {
        logic hit;
        logic miss;
        logic move_done;
        logic out_busy;
    } stat_t;

endpackage

`default_nettype wire

>>> rtl/first_fit_segment_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_unit
// First-fit free segment allocator with coalescing release.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries one command word: allocate
// (first segment at least req_size long, taken from its front) or release
// (insert req_start/req_size in order, merged with touching neighbors).
// Output channel out_valid/out_stall/out_data returns one result word per
// command: status, granted start and the number of free segments held.
// The free table sits in a single-port-read memory; each command scans it
// one entry per cycle, then shifts entries one per cycle on insert or
// removal. After acceptance a command passes scan, decide, entry move,
// final write and result load. The scan examines positions up to the hit,
// or the fill count plus one on a miss. The next command is taken in the
// cycle after the result loads. In_stall is high while a command runs.
// A finished result waits in the output register while the next command
// is already being taken. While out_stall is high the result holds and a
// following command stops before loading its own result.
// Reset empties the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_segment_allocator_unit #(
    parameter int TABLE_ENTRIES = ffsa_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire ffsa_pkg::in_word_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output ffsa_pkg::out_word_t      out_data
);

    ffsa_pkg::ctrl_t ctrl;
    ffsa_pkg::stat_t stat;

    // sequencer
    ffsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    // table and datapath
    ffsa_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .ctrl      (ctrl),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

>>> rtl/ffsa_ctrl.sv
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Command sequencer: scan, decide, entry move, final write, result.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire ffsa_pkg::stat_t stat,
    output ffsa_pkg::ctrl_t      ctrl
);

    ffsa_pkg::state_t state_reg;
    ffsa_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffsa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffsa_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ffsa_pkg::S_SCAN;
                end
            end
            ffsa_pkg::S_SCAN:
            begin
                if (stat.hit || stat.miss)
                begin
                    state_next = ffsa_pkg::S_DECIDE;
                end
            end
            ffsa_pkg::S_DECIDE:
            begin
                state_next = ffsa_pkg::S_MOVE;
            end
            ffsa_pkg::S_MOVE:
            begin
                if (stat.move_done)
                begin
                    state_next = ffsa_pkg::S_WRITE;
                end
            end
            ffsa_pkg::S_WRITE:
            begin
                state_next = ffsa_pkg::S_RESULT;
            end
            ffsa_pkg::S_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ffsa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffsa_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl     = '0;
        in_stall = 1'b1;
        case (state_reg)
            ffsa_pkg::S_IDLE:
            begin
                in_stall    = 1'b0;
                ctrl.accept = in_valid;
            end
            ffsa_pkg::S_SCAN:
            begin
                ctrl.scan_en = 1'b1;
            end
            ffsa_pkg::S_DECIDE:
            begin
                ctrl.decide = 1'b1;
            end
            ffsa_pkg::S_MOVE:
            begin
                ctrl.move_en = 1'b1;
            end
            ffsa_pkg::S_WRITE:
            begin
                ctrl.final_wr = 1'b1;
            end
            ffsa_pkg::S_RESULT:
            begin
                ctrl.load_out = !stat.out_busy;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/ffsa_dp.sv
// ----------------------------------------------------------------------------
// ffsa_dp
// Segment table memory, scan pipeline, decision logic, entry mover and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_dp #(
    parameter int TABLE_ENTRIES = ffsa_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ffsa_pkg::in_word_t  in_data,
    input  wire ffsa_pkg::ctrl_t     ctrl,
    output ffsa_pkg::stat_t          stat,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output ffsa_pkg::out_word_t      out_data
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int AW = ffsa_pkg::ADDR_BITS;
    localparam int SW = ffsa_pkg::SIZE_BITS;
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);
    localparam logic [CW-1:0] ONE        = CW'(1);

    // table memory
    logic [AW-1:0] seg_start_mem [TABLE_ENTRIES];
    logic [SW-1:0] seg_len_mem   [TABLE_ENTRIES];

    // command word
    logic          cmd_reg;
    logic [AW-1:0] rs_reg;
    logic [SW-1:0] size_reg;

    // scan pipeline
    logic [CW-1:0] scan_ptr_reg;
    logic [CW-1:0] eval_idx_reg;
    logic          eval_ok_reg;
    logic          eval_valid_reg;
    logic [AW-1:0] rd_start_reg;
    logic [SW-1:0] rd_len_reg;
    logic [AW-1:0] prev_start_reg;
    logic [SW-1:0] prev_len_reg;
    logic          has_prev_reg;
    logic [AW-1:0] hit_start_reg;
    logic [SW-1:0] hit_len_reg;
    logic [CW-1:0] pos_reg;
    logic          has_next_reg;
    logic [CW-1:0] count_reg;

    // mover and final write
    logic [CW-1:0] mv_ptr_reg;
    logic [CW-1:0] mv_left_reg;
    logic          mv_up_reg;
    logic          wr_pend_reg;
    logic [IW-1:0] wr_idx_reg;
    logic          fin_we_reg;
    logic [IW-1:0] fin_idx_reg;
    logic [AW-1:0] fin_start_reg;
    logic [SW-1:0] fin_len_reg;
    logic [1:0]    res_status_reg;
    logic [AW-1:0] res_grant_reg;

    // result register
    logic                out_valid_reg;
    ffsa_pkg::out_word_t out_word_reg;

    logic          cond;
    logic [IW-1:0] rd_addr;
    logic [CW-1:0] mv_ptr_inc;
    logic [CW-1:0] mv_ptr_dec;

    // decision signals
    logic [SW:0]   rend;
    logic [SW:0]   pend;
    logic [SW:0]   rs_w;
    logic [SW:0]   hs_w;
    logic [SW:0]   both_len;
    logic          merge_prev;
    logic          merge_next;
    logic [CW-1:0] pos_m1;
    logic [1:0]    d_status;
    logic [AW-1:0] d_grant;
    logic          d_fin_we;
    logic [IW-1:0] d_fin_idx;
    logic [AW-1:0] d_fin_start;
    logic [SW-1:0] d_fin_len;
    logic [CW-1:0] d_left;
    logic [CW-1:0] d_ptr;
    logic          d_up;
    logic [CW-1:0] d_count;
    logic [CW+4:0] count_ext;

    // scan compare
    always_comb
    begin
        if (cmd_reg == ffsa_pkg::CMD_RELEASE)
        begin
            cond = (rd_start_reg >= rs_reg);
        end
        else
        begin
            cond = (rd_len_reg >= size_reg);
        end
    end

    assign stat.hit       = ctrl.scan_en && eval_valid_reg && eval_ok_reg && cond;
    assign stat.miss      = ctrl.scan_en && eval_valid_reg && !eval_ok_reg;
    assign stat.move_done = (mv_left_reg == '0) && !wr_pend_reg;
    assign stat.out_busy  = out_valid_reg && out_stall;

    assign rd_addr = ctrl.scan_en ? scan_ptr_reg[IW-1:0] : mv_ptr_reg[IW-1:0];

    // neighbor indexes of the mover pointer
    assign mv_ptr_inc = mv_ptr_reg + ONE;
    assign mv_ptr_dec = mv_ptr_reg - ONE;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
        begin
            seg_start_mem[wr_idx_reg] <= rd_start_reg;
            seg_len_mem[wr_idx_reg]   <= rd_len_reg;
        end
        else if (ctrl.final_wr && fin_we_reg)
        begin
            seg_start_mem[fin_idx_reg] <= fin_start_reg;
            seg_len_mem[fin_idx_reg]   <= fin_len_reg;
        end
        rd_start_reg <= seg_start_mem[rd_addr];
        rd_len_reg   <= seg_len_mem[rd_addr];
    end

    // command capture and scan state
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cmd_reg      <= in_data.cmd;
            rs_reg       <= in_data.req_start;
            size_reg     <= in_data.req_size;
            scan_ptr_reg <= '0;
            has_prev_reg <= 1'b0;
            has_next_reg <= 1'b0;
        end
        else if (ctrl.scan_en)
        begin
            scan_ptr_reg <= scan_ptr_reg + ONE;
            eval_idx_reg <= scan_ptr_reg;
            eval_ok_reg  <= (scan_ptr_reg < count_reg);
            if (stat.hit)
            begin
                pos_reg       <= eval_idx_reg;
                hit_start_reg <= rd_start_reg;
                hit_len_reg   <= rd_len_reg;
                has_next_reg  <= 1'b1;
            end
            else if (stat.miss)
            begin
                pos_reg      <= eval_idx_reg;
                has_next_reg <= 1'b0;
            end
            else if (eval_valid_reg && eval_ok_reg)
            begin
                prev_start_reg <= rd_start_reg;
                prev_len_reg   <= rd_len_reg;
                has_prev_reg   <= 1'b1;
            end
        end
    end

    // scan data valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_valid_reg <= 1'b0;
        end
        else
        begin
            eval_valid_reg <= ctrl.scan_en;
        end
    end

    // decision on the scanned neighbors
    always_comb
    begin
        rs_w       = {2'b00, rs_reg};
        hs_w       = {2'b00, hit_start_reg};
        rend       = rs_w + {1'b0, size_reg};
        pend       = {2'b00, prev_start_reg} + {1'b0, prev_len_reg};
        both_len   = {1'b0, prev_len_reg} + {1'b0, size_reg} + {1'b0, hit_len_reg};
        merge_prev = has_prev_reg && (pend == rs_w);
        merge_next = has_next_reg && (rend == hs_w);
        pos_m1     = pos_reg - ONE;

        d_status    = ffsa_pkg::ST_OK;
        d_grant     = '0;
        d_fin_we    = 1'b0;
        d_fin_idx   = pos_reg[IW-1:0];
        d_fin_start = hit_start_reg;
        d_fin_len   = hit_len_reg;
        d_left      = '0;
        d_ptr       = pos_reg + ONE;
        d_up        = 1'b0;
        d_count     = count_reg;

        if (cmd_reg == ffsa_pkg::CMD_RELEASE)
        begin
            if (size_reg == '0)
            begin
                d_status = ffsa_pkg::ST_OK;
            end
            else if (rend > ffsa_pkg::SPACE_SIZE)
            begin
                d_status = ffsa_pkg::ST_OVERLAP;
            end
            else if (has_prev_reg && (pend > rs_w))
            begin
                d_status = ffsa_pkg::ST_OVERLAP;
            end
            else if (has_next_reg && (rend > hs_w))
            begin
                d_status = ffsa_pkg::ST_OVERLAP;
            end
            else if (merge_prev && merge_next)
            begin
                d_fin_we    = 1'b1;
                d_fin_idx   = pos_m1[IW-1:0];
                d_fin_start = prev_start_reg;
                d_fin_len   = both_len[SW-1:0];
                d_left      = count_reg - ONE - pos_reg;
                d_count     = count_reg - ONE;
            end
            else if (merge_prev)
            begin
                d_fin_we    = 1'b1;
                d_fin_idx   = pos_m1[IW-1:0];
                d_fin_start = prev_start_reg;
                d_fin_len   = prev_len_reg + size_reg;
            end
            else if (merge_next)
            begin
                d_fin_we    = 1'b1;
                d_fin_start = rs_reg;
                d_fin_len   = hit_len_reg + size_reg;
            end
            else if (count_reg >= FULL_COUNT)
            begin
                d_status = ffsa_pkg::ST_FULL;
            end
            else
            begin
                d_fin_we    = 1'b1;
                d_fin_start = rs_reg;
                d_fin_len   = size_reg;
                d_left      = count_reg - pos_reg;
                d_ptr       = count_reg - ONE;
                d_up        = 1'b1;
                d_count     = count_reg + ONE;
            end
        end
        else
        begin
            if ((size_reg == '0) || !has_next_reg)
            begin
                d_status = ffsa_pkg::ST_NOFIT;
            end
            else
            begin
                d_grant = hit_start_reg;
                if (hit_len_reg == size_reg)
                begin
                    d_left  = count_reg - ONE - pos_reg;
                    d_count = count_reg - ONE;
                end
                else
                begin
                    d_fin_we    = 1'b1;
                    d_fin_start = hit_start_reg + size_reg[AW-1:0];
                    d_fin_len   = hit_len_reg - size_reg;
                end
            end
        end
    end

    // decision registers
    always_ff @(posedge clk)
    begin
        if (ctrl.decide)
        begin
            res_status_reg <= d_status;
            res_grant_reg  <= d_grant;
            fin_we_reg     <= d_fin_we;
            fin_idx_reg    <= d_fin_idx;
            fin_start_reg  <= d_fin_start;
            fin_len_reg    <= d_fin_len;
            mv_up_reg      <= d_up;
        end
    end

    // entry mover: one read per cycle, each written back in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            mv_left_reg <= '0;
            mv_ptr_reg  <= '0;
            wr_pend_reg <= 1'b0;
            wr_idx_reg  <= '0;
        end
        else
        begin
            if (ctrl.decide)
            begin
                count_reg   <= d_count;
                mv_left_reg <= d_left;
                mv_ptr_reg  <= d_ptr;
                wr_pend_reg <= 1'b0;
            end
            else if (ctrl.move_en && (mv_left_reg != '0))
            begin
                wr_pend_reg <= 1'b1;
                mv_left_reg <= mv_left_reg - ONE;
                if (mv_up_reg)
                begin
                    wr_idx_reg <= mv_ptr_inc[IW-1:0];
                    mv_ptr_reg <= mv_ptr_dec;
                end
                else
                begin
                    wr_idx_reg <= mv_ptr_dec[IW-1:0];
                    mv_ptr_reg <= mv_ptr_inc;
                end
            end
            else
            begin
                wr_pend_reg <= 1'b0;
            end
        end
    end

    assign count_ext = {5'b00000, count_reg};

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            out_word_reg.status       <= res_status_reg;
            out_word_reg.alloc_start  <= res_grant_reg;
            out_word_reg.free_entries <= count_ext[4:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

endmodule

`default_nettype wire

>>> dv/first_fit_segment_allocator_unit_test.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_unit_test
// Drives allocate and release commands into the segment allocator with random
// idling on both sides and checks every result word against a free-table
// predictor kept in the testbench.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_segment_allocator_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = ffsa_pkg::TABLE_ENTRIES_DEF;
    localparam int AB = ffsa_pkg::ADDR_BITS;
    localparam int CB = ffsa_pkg::COUNT_BITS;
    localparam int SB = ffsa_pkg::SIZE_BITS;
    localparam longint CYCLE_LIMIT = 1000000;

    int errors = 0;

    // one line per mismatch, counted
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // free table predictor and queue of expected result words
    class free_table_board;
        longint seg_start[DEPTH];
        longint seg_len[DEPTH];
        int seg_count;
        ffsa_pkg::out_word_t pending[$];

        function void drop_entry(int pos);
            for (int i = pos; i + 1 < seg_count; i++)
            begin
                seg_start[i] = seg_start[i + 1];
                seg_len[i] = seg_len[i + 1];
            end
            seg_count--;
        endfunction

        function void add_entry(int pos, longint s, longint l);
            for (int i = seg_count; i > pos; i--)
            begin
                seg_start[i] = seg_start[i - 1];
                seg_len[i] = seg_len[i - 1];
            end
            seg_start[pos] = s;
            seg_len[pos] = l;
            seg_count++;
        endfunction

        function logic [1:0] grant(longint size, output longint granted);
            granted = 0;
            if (size == 0)
                return ffsa_pkg::ST_NOFIT;
            for (int i = 0; i < seg_count; i++)
            begin
                if (seg_len[i] >= size)
                begin
                    granted = seg_start[i];
                    if (seg_len[i] == size)
                        drop_entry(i);
                    else
                    begin
                        seg_start[i] += size;
                        seg_len[i] -= size;
                    end
                    return ffsa_pkg::ST_OK;
                end
            end
            return ffsa_pkg::ST_NOFIT;
        endfunction

        function logic [1:0] give_back(longint rs, longint size);
            int pos;
            longint rend;
            longint pend;
            bit mp;
            bit mn;
            pos = 0;
            rend = rs + size;
            mp = 0;
            mn = 0;
            if (size == 0)
                return ffsa_pkg::ST_OK;
            if (rend > (longint'(1) << AB))
                return ffsa_pkg::ST_OVERLAP;
            while (pos < seg_count && seg_start[pos] < rs)
                pos++;
            if (pos > 0)
            begin
                pend = seg_start[pos - 1] + seg_len[pos - 1];
                if (pend > rs)
                    return ffsa_pkg::ST_OVERLAP;
                mp = (pend == rs);
            end
            if (pos < seg_count)
            begin
                if (rend > seg_start[pos])
                    return ffsa_pkg::ST_OVERLAP;
                mn = (rend == seg_start[pos]);
            end
            if (mp && mn)
            begin
                seg_len[pos - 1] += size + seg_len[pos];
                drop_entry(pos);
            end
            else if (mp)
                seg_len[pos - 1] += size;
            else if (mn)
            begin
                seg_start[pos] = rs;
                seg_len[pos] += size;
            end
            else
            begin
                if (seg_count >= DEPTH)
                    return ffsa_pkg::ST_FULL;
                add_entry(pos, rs, size);
            end
            return ffsa_pkg::ST_OK;
        endfunction

        // accepted input word: predict its result
        function void note_command(ffsa_pkg::in_word_t w);
            ffsa_pkg::out_word_t r;
            longint g;
            g = 0;
            if (w.cmd == ffsa_pkg::CMD_ALLOC)
                r.status = grant(longint'(w.req_size), g);
            else
                r.status = give_back(longint'(w.req_start), longint'(w.req_size));
            r.alloc_start = g[AB-1:0];
            r.free_entries = seg_count[CB-1:0];
            pending.push_back(r);
        endfunction

        // accepted result word: compare with oldest expectation
        task check_result(ffsa_pkg::out_word_t got);
            ffsa_pkg::out_word_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result word", 1, 0);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.alloc_start !== want.alloc_start)
                report_mismatch("alloc_start", got.alloc_start, want.alloc_start);
            if (got.free_entries !== want.free_entries)
                report_mismatch("free_entries", got.free_entries, want.free_entries);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    ffsa_pkg::in_word_t in_data = '0;
    logic out_valid;
    logic out_stall = 0;
    ffsa_pkg::out_word_t out_data;

    free_table_board board = new();
    longint cycles = 0;

    first_fit_segment_allocator_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // random gap length, mostly short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // present one word and hold it until accepted
    task automatic send_word(ffsa_pkg::in_word_t w);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1;
        in_data <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_command(w);
    endtask

    task automatic send_cmd(logic c, int s, int z);
        ffsa_pkg::in_word_t w;
        w.cmd = c;
        w.req_start = s[AB-1:0];
        w.req_size = z[SB-1:0];
        send_word(w);
    endtask

    // random size, mostly small
    function automatic int rand_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 64);
        if (r < 95)
            return $urandom_range(1, 4096);
        return $urandom_range(0, 131071);
    endfunction

    // output side: random stalls, check every accepted word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_result(out_data);
            if ($urandom_range(0, 3) == 0)
                out_stall <= ($urandom_range(0, 9) < 7);
            else if ($urandom_range(0, 40) == 0)
                out_stall <= 1;
            else
                out_stall <= 0;
        end
    end

    // timeout watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("first_fit_segment_allocator_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        int z;
        int k;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty table, zero sizes, extremes, merges, full table
        send_cmd(ffsa_pkg::CMD_ALLOC, 0, 1);
        send_cmd(ffsa_pkg::CMD_ALLOC, 65535, 0);
        send_cmd(ffsa_pkg::CMD_RELEASE, 1234, 0);
        send_cmd(ffsa_pkg::CMD_RELEASE, 65535, 2);
        send_cmd(ffsa_pkg::CMD_RELEASE, 0, 65536);
        send_cmd(ffsa_pkg::CMD_ALLOC, 0, 65536);
        send_cmd(ffsa_pkg::CMD_ALLOC, 0, 131071);
        send_cmd(ffsa_pkg::CMD_RELEASE, 100, 10);
        send_cmd(ffsa_pkg::CMD_RELEASE, 105, 2);
        send_cmd(ffsa_pkg::CMD_RELEASE, 90, 10);
        send_cmd(ffsa_pkg::CMD_RELEASE, 120, 10);
        send_cmd(ffsa_pkg::CMD_RELEASE, 110, 10);
        send_cmd(ffsa_pkg::CMD_ALLOC, 0, 41);
        send_cmd(ffsa_pkg::CMD_ALLOC, 0, 5);
        send_cmd(ffsa_pkg::CMD_ALLOC, 0, 35);
        for (int i = 0; i < 17; i++)
            send_cmd(ffsa_pkg::CMD_RELEASE, i * 4, 2);
        send_cmd(ffsa_pkg::CMD_RELEASE, 2, 2);
        send_cmd(ffsa_pkg::CMD_RELEASE, 65535, 1);

        // random: allocates and releases about equally often, most releases at 64-aligned starts
        k = 0;
        while (k < 1900)
        begin
            z = rand_size();
            if ($urandom_range(0, 1) == 0)
                send_cmd(ffsa_pkg::CMD_ALLOC, $urandom_range(0, 65535), z);
            else if ($urandom_range(0, 9) < 8)
                send_cmd(ffsa_pkg::CMD_RELEASE, $urandom_range(0, 1023) * 64,
                         $urandom_range(1, 64));
            else
                send_cmd(ffsa_pkg::CMD_RELEASE, $urandom_range(0, 65535), z);
            k++;
        end
        in_valid <= 0;

        // drain
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("first_fit_segment_allocator_unit regression: pass");
        else
            $display("first_fit_segment_allocator_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/ffsa_pkg.sv
rtl/ffsa_ctrl.sv
rtl/ffsa_dp.sv
rtl/first_fit_segment_allocator_unit.sv
dv/first_fit_segment_allocator_unit_test.sv
